// ===== rtl/qshe_pkg.sv =====
// Shared types and constants for the QUIC stream header encoder.
package qshe_pkg;

	localparam int unsigned VAL_W   = 62;
	localparam int unsigned SIZE_W  = 14;
	localparam int unsigned SPACE_W = 16;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [7:0]  TYPE_BASE   = 8'h0a;
	localparam logic [7:0]  TYPE_OFFSET = 8'h04;
	localparam logic [15:0] LEN_PREFIX  = 16'h4000;
	localparam logic [SPACE_W-1:0] MIN_SPACE = SPACE_W'(1 + 8 + 8 + 8 + 1);

	// back end field phases
	localparam logic [1:0] PH_SID  = 2'd0;
	localparam logic [1:0] PH_OFF  = 2'd1;
	localparam logic [1:0] PH_LEN0 = 2'd2;
	localparam logic [1:0] PH_LEN1 = 2'd3;

	// classified request: varints left-aligned with prefix, varint byte counts minus one
	typedef struct packed {
		logic        fail;
		logic [7:0]  type_byte;
		logic [63:0] sid_al;
		logic [2:0]  sid_last;
		logic        has_off;
		logic [63:0] off_al;
		logic [2:0]  off_last;
		logic [15:0] len_word;
		logic [LEN_W-1:0] total;
	} qshe_desc_t;

	typedef struct packed {
		logic       push;
		qshe_desc_t desc;
	} qshe_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qshe_qstat_t;

	// varint size code: bytes minus one (0, 1, 3, 7)
	function automatic logic [2:0] varint_last(input logic [VAL_W-1:0] v);
		logic [2:0] r;
		if (v[VAL_W-1:6] == '0)
			r = 3'd0;
		else if (v[VAL_W-1:14] == '0)
			r = 3'd1;
		else if (v[VAL_W-1:30] == '0)
			r = 3'd3;
		else
			r = 3'd7;
		return r;
	endfunction

	function automatic logic [63:0] varint_align(input logic [VAL_W-1:0] v,
		input logic [2:0] last);
		logic [63:0] r;
		case (last)
			3'd0: r = {2'b00, v[5:0], 56'd0};
			3'd1: r = {2'b01, v[13:0], 48'd0};
			3'd3: r = {2'b10, v[29:0], 32'd0};
			default: r = {2'b11, v[61:0]};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/qshe_if.sv =====
// Request and header-byte channel interfaces.
interface qshe_req_if import qshe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VAL_W-1:0]   stream_ident;
	logic [VAL_W-1:0]   stream_offset;
	logic [SIZE_W-1:0]  payload_size;
	logic               fin_flag;
	logic [SPACE_W-1:0] space_available;

	modport source (output valid, stream_ident, stream_offset, payload_size, fin_flag,
		space_available, input ready);
	modport sink (input valid, stream_ident, stream_offset, payload_size, fin_flag,
		space_available, output ready);
endinterface

interface qshe_hdr_if import qshe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [7:0]       header_byte;
	logic             last_byte;
	logic             encode_failed;
	logic [LEN_W-1:0] header_length;

	modport source (output valid, header_byte, last_byte, encode_failed, header_length,
		input ready);
	modport sink (input valid, header_byte, last_byte, encode_failed, header_length,
		output ready);
endinterface

// ===== rtl/qshe_front.sv =====
// Front end: accepts requests and classifies them into descriptors.
module qshe_front import qshe_pkg::*; (
	qshe_req_if.sink   req,
	input  qshe_qstat_t qst,
	output qshe_push_t  wr
);

	logic [2:0] sid_last, off_last;
	logic       has_off;
	logic [LEN_W-1:0] off_bytes;

	assign sid_last  = varint_last(req.stream_ident);
	assign off_last  = varint_last(req.stream_offset);
	assign has_off   = (req.stream_offset != '0);
	assign off_bytes = has_off ? LEN_W'(off_last) + LEN_W'(1) : '0;

	assign req.ready = !qst.full;

	always_comb begin
		wr.push           = req.valid && !qst.full;
		wr.desc.fail      = (req.space_available < MIN_SPACE);
		wr.desc.type_byte = TYPE_BASE | (has_off ? TYPE_OFFSET : 8'd0)
			| {7'd0, req.fin_flag};
		wr.desc.sid_al    = varint_align(req.stream_ident, sid_last);
		wr.desc.sid_last  = sid_last;
		wr.desc.has_off   = has_off;
		wr.desc.off_al    = varint_align(req.stream_offset, off_last);
		wr.desc.off_last  = off_last;
		wr.desc.len_word  = LEN_PREFIX | {2'b00, req.payload_size};
		wr.desc.total     = LEN_W'(4) + LEN_W'(sid_last) + off_bytes;
	end

endmodule

// ===== rtl/qshe_queue.sv =====
// Descriptor queue between front and back ends.
module qshe_queue import qshe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qshe_push_t  wr,
	input  logic        pop,
	output qshe_qstat_t qst,
	output qshe_desc_t  rdata
);

	qshe_desc_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign qst.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qst.empty = (cnt_q == '0);
	assign do_push   = wr.push && !qst.full;
	assign do_pop    = pop && !qst.empty;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr.desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != QCNT_W'(QDEPTH) && cnt_q != '0) |-> wr_ptr_q != rd_ptr_q)
		else $error("queue pointers collide while partly full");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qst.empty |=> $past(cnt_q) == cnt_q || do_push || $past(do_push))
		else $error("queue count moved while empty");

endmodule

// ===== rtl/qshe_back.sv =====
// Back end: serializes descriptors into header beats.
module qshe_back import qshe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qshe_qstat_t qst,
	input  qshe_desc_t  rdata,
	output logic        pop,
	qshe_hdr_if.source  hdr
);

	logic             busy_q;
	logic [1:0]       phase_q;
	logic [2:0]       cnt_q;
	logic [63:0]      sh_q;
	logic [63:0]      off_q;
	logic [2:0]       off_last_q;
	logic             has_off_q;
	logic [15:0]      len_q;
	logic [LEN_W-1:0] tot_q;

	logic             ov_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             fail_q;
	logic [LEN_W-1:0] hlen_q;

	logic adv;

	assign adv = !ov_q || hdr.ready;
	assign pop = adv && !busy_q && !qst.empty;

	assign hdr.valid         = ov_q;
	assign hdr.header_byte   = byte_q;
	assign hdr.last_byte     = last_q;
	assign hdr.encode_failed = fail_q;
	assign hdr.header_length = hlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_SID;
			ov_q    <= 1'b0;
		end else if (adv) begin
			ov_q <= busy_q || !qst.empty;
			if (!busy_q) begin
				if (!qst.empty && !rdata.fail) begin
					busy_q  <= 1'b1;
					phase_q <= PH_SID;
				end
			end else begin
				case (phase_q)
					PH_SID: begin
						if (cnt_q == '0)
							phase_q <= has_off_q ? PH_OFF : PH_LEN0;
					end
					PH_OFF: begin
						if (cnt_q == '0)
							phase_q <= PH_LEN0;
					end
					PH_LEN0: phase_q <= PH_LEN1;
					PH_LEN1: busy_q <= 1'b0;
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!busy_q) begin
				byte_q     <= rdata.fail ? 8'd0 : rdata.type_byte;
				last_q     <= rdata.fail;
				fail_q     <= rdata.fail;
				hlen_q     <= '0;
				sh_q       <= rdata.sid_al;
				cnt_q      <= rdata.sid_last;
				off_q      <= rdata.off_al;
				off_last_q <= rdata.off_last;
				has_off_q  <= rdata.has_off;
				len_q      <= rdata.len_word;
				tot_q      <= rdata.total;
			end else begin
				fail_q <= 1'b0;
				case (phase_q)
					PH_SID, PH_OFF: begin
						byte_q <= sh_q[63:56];
						last_q <= 1'b0;
						hlen_q <= '0;
						if (cnt_q == '0 && phase_q == PH_SID && has_off_q) begin
							sh_q  <= off_q;
							cnt_q <= off_last_q;
						end else begin
							sh_q  <= {sh_q[55:0], 8'd0};
							cnt_q <= cnt_q - 3'd1;
						end
					end
					PH_LEN0: begin
						byte_q <= len_q[15:8];
						last_q <= 1'b0;
						hlen_q <= '0;
					end
					default: begin
						byte_q <= len_q[7:0];
						last_q <= 1'b1;
						hlen_q <= tot_q;
					end
				endcase
			end
		end
	end

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.encode_failed |-> hdr.last_byte && hdr.header_length == '0
		&& hdr.header_byte == 8'd0)
		else $error("failure beat malformed");
	a_len_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && !hdr.last_byte |-> hdr.header_length == '0)
		else $error("header length on non-final beat");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.last_byte && !hdr.encode_failed |->
		hdr.header_length >= LEN_W'(4) && hdr.header_length <= LEN_W'(19))
		else $error("header length out of range");
	a_len1_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && phase_q == PH_LEN1 && adv |=> hdr.valid && hdr.last_byte)
		else $error("final length byte not marked last");

endmodule

// ===== rtl/quic_stream_header_encoder.sv =====
// Top level of the QUIC STREAM frame header encoder.
//
//  channel | dir | beat
//  req     | in  | stream_ident, stream_offset, payload_size, fin_flag, space_available
//  hdr     | out | header_byte, last_byte, encode_failed, header_length
//
// One request gives 4 to 19 header beats (or one failure beat), one beat per cycle while
// hdr.ready is high, from the back-end serializer; consecutive requests run with no gap.
// Requests enter through a 4-entry descriptor queue; req.ready drops only when it is full.
// hdr.ready low holds the output register and stalls the serializer only.
// Reset clears queue pointers, serializer state and output valid.
module quic_stream_header_encoder import qshe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	qshe_req_if.sink   req,
	qshe_hdr_if.source hdr
);

	qshe_push_t  wr;
	qshe_qstat_t qst;
	qshe_desc_t  rdata;
	logic        pop;

	qshe_front u_front (
		.req (req),
		.qst (qst),
		.wr  (wr)
	);

	qshe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.qst    (qst),
		.rdata  (rdata)
	);

	qshe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qst    (qst),
		.rdata  (rdata),
		.pop    (pop),
		.hdr    (hdr)
	);

endmodule

// ===== sim/tb.sv =====
// Testbench for the QUIC STREAM frame header encoder: directed and random requests, byte-level checking.
`timescale 1ns / 100ps

module tb import qshe_pkg::*;;

	typedef struct packed {
		logic [VAL_W-1:0]   sid;
		logic [VAL_W-1:0]   off;
		logic [SIZE_W-1:0]  size;
		logic               fin;
		logic [SPACE_W-1:0] space;
	} stream_req_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic             failed;
		logic [LEN_W-1:0] length;
	} hdr_beat_t;

	class hdr_scoreboard;
		hdr_beat_t header_beats[$];
		int        mismatches;

		function new();
			mismatches = 0;
		endfunction

		function automatic void put_varint(input logic [VAL_W-1:0] v,
			ref logic [7:0] buf_q[$]);
			int          nbytes;
			logic [1:0]  pfx;
			logic [63:0] word;
			if (v[VAL_W-1:6] == '0) begin
				nbytes = 1;
				pfx = 2'd0;
			end else if (v[VAL_W-1:14] == '0) begin
				nbytes = 2;
				pfx = 2'd1;
			end else if (v[VAL_W-1:30] == '0) begin
				nbytes = 4;
				pfx = 2'd2;
			end else begin
				nbytes = 8;
				pfx = 2'd3;
			end
			word = 64'(v) | (64'(pfx) << (8 * nbytes - 2));
			for (int i = nbytes - 1; i >= 0; i--)
				buf_q.push_back(word[8*i +: 8]);
		endfunction

		function void note_request(stream_req_t r);
			logic [7:0]  hdr_q[$];
			logic [7:0]  type_byte;
			logic [15:0] len_word;
			if (r.space < MIN_SPACE) begin
				header_beats.push_back(hdr_beat_t'{8'd0, 1'b1, 1'b1, '0});
				return;
			end
			type_byte = TYPE_BASE | (r.off != '0 ? TYPE_OFFSET : 8'd0) | 8'(r.fin);
			hdr_q.push_back(type_byte);
			put_varint(r.sid, hdr_q);
			if (r.off != '0)
				put_varint(r.off, hdr_q);
			len_word = LEN_PREFIX | 16'(r.size);
			hdr_q.push_back(len_word[15:8]);
			hdr_q.push_back(len_word[7:0]);
			foreach (hdr_q[k]) begin
				if (k == hdr_q.size() - 1)
					header_beats.push_back(hdr_beat_t'{hdr_q[k], 1'b1, 1'b0,
						LEN_W'(hdr_q.size())});
				else
					header_beats.push_back(hdr_beat_t'{hdr_q[k], 1'b0, 1'b0, '0});
			end
		endfunction

		function void check_beat(hdr_beat_t got);
			hdr_beat_t want;
			if (header_beats.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected beat byte=%h last=%b fail=%b len=%0d", $time,
						got.data, got.last, got.failed, got.length);
				mismatches++;
				return;
			end
			want = header_beats.pop_front();
			if (got !== want) begin
				if (mismatches < 10)
					$display("%0t: mismatch exp %h/%b/%b/%0d got %h/%b/%b/%0d",
						$time, want.data, want.last, want.failed, want.length,
						got.data, got.last, got.failed, got.length);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return header_beats.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	qshe_req_if req_ch ();
	qshe_hdr_if hdr_ch ();

	quic_stream_header_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.hdr    (hdr_ch)
	);

	hdr_scoreboard sb = new();

	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned hold_request;
	int unsigned hold_left;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// output ready; long hold-offs are counted here
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			hdr_ch.ready <= 1'b0;
		end else begin
			hdr_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hdr_ch.valid && hdr_ch.ready)
				sb.check_beat(hdr_beat_t'{hdr_ch.header_byte, hdr_ch.last_byte,
					hdr_ch.encode_failed, hdr_ch.header_length});
			if (req_ch.valid && req_ch.ready)
				sb.note_request(stream_req_t'{req_ch.stream_ident, req_ch.stream_offset,
					req_ch.payload_size, req_ch.fin_flag, req_ch.space_available});
		end
	end

	function automatic stream_req_t mk_req(logic [VAL_W-1:0] sid, logic [VAL_W-1:0] off,
		logic [SIZE_W-1:0] size, logic fin, logic [SPACE_W-1:0] space);
		return stream_req_t'{sid, off, size, fin, space};
	endfunction

	function automatic logic [VAL_W-1:0] rand_varint_val();
		logic [63:0] w;
		int unsigned k;
		w = {$urandom, $urandom};
		k = $urandom_range(9);
		case (k)
			0: return '0;
			1: return VAL_W'(w[5:0]);
			2: return VAL_W'($urandom_range(16383, 64));
			3: return VAL_W'($urandom_range(32'h3fff_ffff, 16384));
			4: begin
				case ($urandom_range(6))
					0: return VAL_W'(63);
					1: return VAL_W'(64);
					2: return VAL_W'(16383);
					3: return VAL_W'(16384);
					4: return VAL_W'(32'h3fff_ffff);
					5: return VAL_W'(32'h4000_0000);
					default: return '1;
				endcase
			end
			default: return w[VAL_W-1:0];
		endcase
	endfunction

	function automatic stream_req_t rand_req();
		stream_req_t r;
		r.sid = rand_varint_val();
		r.off = ($urandom_range(9) < 3) ? '0 : rand_varint_val();
		r.size = SIZE_W'($urandom_range(16383));
		r.fin = 1'($urandom_range(1));
		case ($urandom_range(19))
			0, 1, 2: r.space = SPACE_W'($urandom_range(25));
			3: r.space = MIN_SPACE;
			4: r.space = '1;
			default: r.space = SPACE_W'($urandom_range(65535, 26));
		endcase
		return r;
	endfunction

	task automatic send_req(stream_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.stream_ident    <= r.sid;
		req_ch.stream_offset   <= r.off;
		req_ch.payload_size    <= r.size;
		req_ch.fin_flag        <= r.fin;
		req_ch.space_available <= r.space;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic send_random(int unsigned count);
		repeat (count) send_req(rand_req());
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_drain();
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	initial begin
		stream_req_t directed[$];
		int unsigned phase_cfg[4][2];

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.stream_ident = '0;
		req_ch.stream_offset = '0;
		req_ch.payload_size = '0;
		req_ch.fin_flag = 1'b0;
		req_ch.space_available = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		phase_cfg = '{'{0, 0}, '{84, 0}, '{0, 84}, '{9, 9}};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		directed = '{
			mk_req('0, '0, '0, 1'b0, MIN_SPACE),
			mk_req('1, '1, '1, 1'b1, '1),
			mk_req(VAL_W'(63), '0, SIZE_W'(1), 1'b0, SPACE_W'(100)),
			mk_req(VAL_W'(64), VAL_W'(63), SIZE_W'(2), 1'b1, SPACE_W'(200)),
			mk_req(VAL_W'(16383), VAL_W'(64), '0, 1'b0, SPACE_W'(300)),
			mk_req(VAL_W'(16384), VAL_W'(16383), '1, 1'b0, SPACE_W'(1000)),
			mk_req(VAL_W'(32'h3fff_ffff), VAL_W'(16384), SIZE_W'(16), 1'b1, '1),
			mk_req(VAL_W'(32'h4000_0000), VAL_W'(32'h3fff_ffff), SIZE_W'(64), 1'b0, '1),
			mk_req('0, VAL_W'(32'h4000_0000), SIZE_W'(8191), 1'b1, SPACE_W'(27)),
			mk_req('1, '0, '0, 1'b1, MIN_SPACE),
			mk_req(VAL_W'(1), VAL_W'(1), SIZE_W'(8192), 1'b0, SPACE_W'(40000)),
			mk_req('1, '1, '1, 1'b1, MIN_SPACE - SPACE_W'(1)),
			mk_req('0, '0, '0, 1'b0, '0),
			mk_req(VAL_W'(5), VAL_W'(9), SIZE_W'(7), 1'b0, SPACE_W'(1)),
			mk_req({2'b10, {(VAL_W-2){1'b0}}}, {1'b0, {(VAL_W-1){1'b1}}}, SIZE_W'(5461),
				1'b0, SPACE_W'(16'h8000)),
			mk_req({(VAL_W/2){2'b01}}, {(VAL_W/2){2'b10}}, SIZE_W'(10922), 1'b1,
				SPACE_W'(16'h7fff)),
			mk_req(VAL_W'(32'h2000_0000), '0, SIZE_W'(3), 1'b0, SPACE_W'(26)),
			mk_req(VAL_W'(8191), VAL_W'(40), SIZE_W'(100), 1'b1, SPACE_W'(50))
		};
		foreach (directed[i]) send_req(directed[i]);
		req_ch.valid <= 1'b0;
		wait_drain();

		foreach (phase_cfg[p]) begin
			tx_idle_pct = phase_cfg[p][0];
			rx_stall_pct = phase_cfg[p][1];
			send_random(90);
			wait_drain();
		end

		// back-pressure: output held off while requests keep coming
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_request = 300;
		send_random(40);
		wait_drain();

		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
